// ===== rtl/dtep_pkg.sv =====
// ----------------------------------------------------------------------------
// dtep_pkg
// Shared types, character codes and lookup tables for the date text parser.
// ----------------------------------------------------------------------------
package dtep_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0]  CH_SPACE  = 8'h20;
  localparam logic [7:0]  CH_HYPHEN = 8'h2D;
  localparam logic [7:0]  CH_D      = 8'h64;
  localparam logic [23:0] TRAILER   = 24'h540D0A;

  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] chr;
    logic       is_dig;
    logic [3:0] dval;
    logic       last;
  } char_item_t;

  function automatic logic [23:0] month_name(input logic [3:0] idx);
    case (idx)
      4'd0:    month_name = 24'h6A616E;
      4'd1:    month_name = 24'h666562;
      4'd2:    month_name = 24'h6D6172;
      4'd3:    month_name = 24'h617072;
      4'd4:    month_name = 24'h6D6179;
      4'd5:    month_name = 24'h6A756E;
      4'd6:    month_name = 24'h6A756C;
      4'd7:    month_name = 24'h617567;
      4'd8:    month_name = 24'h736570;
      4'd9:    month_name = 24'h6F6374;
      4'd10:   month_name = 24'h6E6F76;
      4'd11:   month_name = 24'h646563;
      default: month_name = 24'h000000;
    endcase
  endfunction

  function automatic logic [15:0] month_adjust(input logic [3:0] idx);
    case (idx)
      4'd0:    month_adjust = 16'hFFFF;
      4'd1:    month_adjust = 16'd30;
      4'd2:    month_adjust = 16'd59;
      4'd3:    month_adjust = 16'd90;
      4'd4:    month_adjust = 16'd120;
      4'd5:    month_adjust = 16'd151;
      4'd6:    month_adjust = 16'd181;
      4'd7:    month_adjust = 16'd212;
      4'd8:    month_adjust = 16'd243;
      4'd9:    month_adjust = 16'd273;
      4'd10:   month_adjust = 16'd304;
      4'd11:   month_adjust = 16'd334;
      default: month_adjust = 16'd0;
    endcase
  endfunction

  // {hit, hours}
  function automatic logic [4:0] zone_hours(input logic [7:0] c);
    case (c)
      8'h70:   zone_hours = {1'b1, 4'd8};
      8'h6D:   zone_hours = {1'b1, 4'd7};
      8'h63:   zone_hours = {1'b1, 4'd6};
      8'h65:   zone_hours = {1'b1, 4'd5};
      8'h61:   zone_hours = {1'b1, 4'd4};
      8'h79:   zone_hours = {1'b1, 4'd9};
      8'h68:   zone_hours = {1'b1, 4'd10};
      default: zone_hours = {1'b0, 4'd0};
    endcase
  endfunction

endpackage

// ===== rtl/dtep_front.sv =====
// ----------------------------------------------------------------------------
// dtep_front
// Accepts characters, folds upper case letters and classifies digits.
// ----------------------------------------------------------------------------
module dtep_front
  import dtep_pkg::*;
(
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_last_char,
  input  logic       q_full,
  output logic       q_push,
  output char_item_t q_item
);

  logic is_upper;
  logic is_dig;

  assign is_upper = (in_char_in >= 8'h41) && (in_char_in <= 8'h5A);
  assign is_dig   = (in_char_in >= 8'h30) && (in_char_in <= 8'h39);

  assign in_stall      = q_full;
  assign q_push        = in_valid && !q_full;
  assign q_item.raw    = in_char_in;
  assign q_item.chr    = is_upper ? (in_char_in + 8'h20) : in_char_in;
  assign q_item.is_dig = is_dig;
  assign q_item.dval   = is_dig ? 4'(in_char_in - 8'h30) : 4'd0;
  assign q_item.last   = in_last_char;

endmodule

// ===== rtl/dtep_queue.sv =====
// ----------------------------------------------------------------------------
// dtep_queue
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module dtep_queue
  import dtep_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  char_item_t wr_item,
  output logic       full,
  input  logic       pop,
  output logic       rd_valid,
  output char_item_t rd_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  char_item_t             entry_r [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = entry_r[rd_ptr_r];
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ===== rtl/dtep_back.sv =====
// ----------------------------------------------------------------------------
// dtep_back
// Parses queued characters, finishes the message and computes epoch seconds.
// ----------------------------------------------------------------------------
module dtep_back
  import dtep_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  char_item_t        q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [31:0] out_epoch_seconds,
  output logic [2:0]        out_status
);

  localparam logic [3:0] PH_WDAY  = 4'd0;
  localparam logic [3:0] PH_DAY   = 4'd1;
  localparam logic [3:0] PH_MON   = 4'd2;
  localparam logic [3:0] PH_MSKIP = 4'd3;
  localparam logic [3:0] PH_YEAR  = 4'd4;
  localparam logic [3:0] PH_HOUR  = 4'd5;
  localparam logic [3:0] PH_MIN   = 4'd6;
  localparam logic [3:0] PH_SEC   = 4'd7;
  localparam logic [3:0] PH_HYPH  = 4'd8;
  localparam logic [3:0] PH_ZONE  = 4'd9;
  localparam logic [3:0] PH_DST   = 4'd10;
  localparam logic [3:0] PH_DONE  = 4'd11;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TRAILER    = 3'd1;
  localparam logic [2:0] ST_INCOMPLETE = 3'd2;
  localparam logic [2:0] ST_MONTH      = 3'd3;
  localparam logic [2:0] ST_HYPHEN     = 3'd4;
  localparam logic [2:0] ST_ZONE       = 3'd5;

  localparam logic [2:0] B_RUN   = 3'd0;
  localparam logic [2:0] B_FLUSH = 3'd1;
  localparam logic [2:0] B_MUL0  = 3'd2;
  localparam logic [2:0] B_MUL1  = 3'd3;
  localparam logic [2:0] B_MUL2  = 3'd4;
  localparam logic [2:0] B_MUL3  = 3'd5;
  localparam logic [2:0] B_OUT   = 3'd6;

  localparam logic [2:0] FLUSH_MAX = 3'd4;

  logic [3:0]         phase_r, phase_nxt, f_phase;
  logic [15:0]        acc_r, acc_nxt, f_acc;
  logic [1:0]         dcnt_r, dcnt_nxt, f_dcnt;
  logic [15:0]        mon_r, mon_nxt, f_mon;
  logic [15:0]        doy_r, doy_nxt, f_doy;
  logic signed [16:0] years_r, years_nxt, f_years;
  logic [7:0]         hour_r, hour_nxt, f_hour;
  logic [6:0]         min_r, min_nxt, f_min;
  logic [6:0]         sec_r, sec_nxt, f_sec;
  logic [3:0]         zone_r, zone_nxt, f_zone;
  logic               dst_r, dst_nxt, f_dst;
  logic [23:0]        recent_r, recent_nxt;
  logic [2:0]         err_r, err_nxt, f_err;
  logic [2:0]         bstate_r, bstate_nxt;
  logic [2:0]         flush_cnt_r, flush_cnt_nxt;
  logic [31:0]        t_r, t_nxt;
  logic [2:0]         stat_r, stat_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_epoch_r, out_epoch_nxt;
  logic [2:0]         out_status_r, out_status_nxt;

  logic               feed_en;
  logic               clr;
  logic [7:0]         f_c;
  logic               f_is_dig;
  logic [3:0]         f_dval;

  logic [19:0]        acc_mul;
  logic [15:0]        acc_sat;
  logic [16:0]        yrs_calc;
  logic [16:0]        yrs_p2;
  logic [7:0]         hms_v;
  logic               mon_hit;
  logic [15:0]        mon_adj;
  logic [4:0]         zone_lu;

  logic signed [26:0] ymul;
  logic [17:0]        y1;
  logic [17:0]        y1n;
  logic [17:0]        q18;
  logic [31:0]        epoch0;
  logic [31:0]        hr32;

  assign f_c      = (bstate_r == B_RUN) ? q_item.chr : 8'd0;
  assign f_is_dig = (bstate_r == B_RUN) ? q_item.is_dig : 1'b0;
  assign f_dval   = (bstate_r == B_RUN) ? q_item.dval : 4'd0;

  assign acc_mul  = {4'b0, acc_r} * 20'd10 + {16'b0, f_dval};
  assign acc_sat  = (acc_mul > 20'd65535) ? 16'hFFFF : acc_mul[15:0];
  assign yrs_calc = {1'b0, acc_r} - 17'd70;
  assign yrs_p2   = yrs_calc + 17'd2;
  assign hms_v    = f_is_dig ? ({4'b0, acc_r[3:0]} * 8'd10 + {4'b0, f_dval}) : acc_r[7:0];
  assign zone_lu  = zone_hours(f_c);

  always_comb begin
    mon_hit = 1'b0;
    mon_adj = 16'd0;
    for (int i = 0; i < 12; i++) begin
      if (!mon_hit && ({mon_r, f_c} == month_name(4'(i)))) begin
        mon_hit = 1'b1;
        mon_adj = month_adjust(4'(i));
      end
    end
  end

  always_comb begin
    f_phase = phase_r;
    f_acc   = acc_r;
    f_dcnt  = dcnt_r;
    f_mon   = mon_r;
    f_doy   = doy_r;
    f_years = years_r;
    f_hour  = hour_r;
    f_min   = min_r;
    f_sec   = sec_r;
    f_zone  = zone_r;
    f_dst   = dst_r;
    f_err   = err_r;
    case (phase_r)
      PH_WDAY: begin
        if (f_c == CH_SPACE) f_phase = PH_DAY;
      end
      PH_MSKIP: begin
        if (f_c == CH_SPACE) f_phase = PH_YEAR;
      end
      PH_DAY, PH_YEAR: begin
        if (f_is_dig) begin
          f_acc  = (dcnt_r != 2'd0) ? acc_sat : {12'b0, f_dval};
          f_dcnt = 2'd1;
        end else if (dcnt_r != 2'd0) begin
          f_dcnt = 2'd0;
          if (phase_r == PH_DAY) begin
            f_doy   = acc_r;
            f_mon   = 16'd0;
            f_phase = PH_MON;
          end else begin
            f_years = yrs_calc;
            if (($signed(doy_r) > 16'sd59) && (yrs_p2[1:0] != 2'd0)) begin
              f_doy = doy_r - 16'd1;
            end
            f_phase = PH_HOUR;
          end
        end
      end
      PH_MON: begin
        if (dcnt_r < 2'd2) begin
          f_mon  = {mon_r[7:0], f_c};
          f_dcnt = dcnt_r + 2'd1;
        end else begin
          f_dcnt = 2'd0;
          if (!mon_hit) begin
            f_err   = ST_MONTH;
            f_phase = PH_DONE;
          end else begin
            f_doy   = doy_r + mon_adj;
            f_phase = PH_MSKIP;
          end
        end
      end
      PH_HOUR, PH_MIN, PH_SEC: begin
        if (dcnt_r == 2'd0) begin
          if (f_is_dig) begin
            f_acc  = {12'b0, f_dval};
            f_dcnt = 2'd1;
          end
        end else begin
          f_dcnt = 2'd0;
          if (phase_r == PH_HOUR) f_hour = hms_v;
          else if (phase_r == PH_MIN) f_min = hms_v[6:0];
          else f_sec = hms_v[6:0];
          f_phase = phase_r + 4'd1;
        end
      end
      PH_HYPH: begin
        if (f_c == CH_HYPHEN) begin
          f_phase = PH_ZONE;
        end else begin
          f_err   = ST_HYPHEN;
          f_phase = PH_DONE;
        end
      end
      PH_ZONE: begin
        if (zone_lu[4]) begin
          f_zone  = zone_lu[3:0];
          f_phase = PH_DST;
        end else begin
          f_err   = ST_ZONE;
          f_phase = PH_DONE;
        end
      end
      PH_DST: begin
        f_dst   = (f_c == CH_D);
        f_phase = PH_DONE;
      end
      default: begin
      end
    endcase
  end

  assign ymul   = years_r * 27'sd365;
  assign y1     = {years_r[16], years_r} + 18'd1;
  assign y1n    = 18'd0 - y1;
  assign q18    = y1[17] ? (18'd0 - (y1n >> 2)) : (y1 >> 2);
  assign epoch0 = 32'(ymul) + 32'($signed(q18)) + 32'($signed(doy_r));
  assign hr32   = {24'b0, hour_r} + {28'b0, zone_r} - {31'b0, dst_r};

  always_comb begin
    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    dcnt_nxt       = dcnt_r;
    mon_nxt        = mon_r;
    doy_nxt        = doy_r;
    years_nxt      = years_r;
    hour_nxt       = hour_r;
    min_nxt        = min_r;
    sec_nxt        = sec_r;
    zone_nxt       = zone_r;
    dst_nxt        = dst_r;
    recent_nxt     = recent_r;
    err_nxt        = err_r;
    bstate_nxt     = bstate_r;
    flush_cnt_nxt  = flush_cnt_r;
    t_nxt          = t_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r;
    out_epoch_nxt  = out_epoch_r;
    out_status_nxt = out_status_r;
    feed_en        = 1'b0;
    clr            = 1'b0;
    q_pop          = 1'b0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (bstate_r)
      B_RUN: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          feed_en    = 1'b1;
          recent_nxt = {recent_r[15:0], q_item.raw};
          if (q_item.last) begin
            bstate_nxt    = B_FLUSH;
            flush_cnt_nxt = 3'd0;
          end
        end
      end
      B_FLUSH: begin
        if (recent_r != TRAILER) begin
          stat_nxt   = ST_TRAILER;
          t_nxt      = 32'd0;
          bstate_nxt = B_OUT;
        end else if (phase_r == PH_DONE) begin
          if (err_r != ST_OK) begin
            stat_nxt   = err_r;
            t_nxt      = 32'd0;
            bstate_nxt = B_OUT;
          end else begin
            bstate_nxt = B_MUL0;
          end
        end else if (flush_cnt_r == FLUSH_MAX) begin
          stat_nxt   = ST_INCOMPLETE;
          t_nxt      = 32'd0;
          bstate_nxt = B_OUT;
        end else begin
          feed_en       = 1'b1;
          flush_cnt_nxt = flush_cnt_r + 3'd1;
        end
      end
      B_MUL0: begin
        t_nxt      = epoch0;
        bstate_nxt = B_MUL1;
      end
      B_MUL1: begin
        t_nxt      = t_r * 32'd24 + hr32;
        bstate_nxt = B_MUL2;
      end
      B_MUL2: begin
        t_nxt      = t_r * 32'd60 + {25'b0, min_r};
        bstate_nxt = B_MUL3;
      end
      B_MUL3: begin
        t_nxt      = t_r * 32'd60 + {25'b0, sec_r};
        stat_nxt   = ST_OK;
        bstate_nxt = B_OUT;
      end
      B_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_epoch_nxt  = t_r;
          out_status_nxt = stat_r;
          clr            = 1'b1;
          bstate_nxt     = B_RUN;
        end
      end
      default: begin
        bstate_nxt = B_RUN;
      end
    endcase

    if (feed_en) begin
      phase_nxt = f_phase;
      acc_nxt   = f_acc;
      dcnt_nxt  = f_dcnt;
      mon_nxt   = f_mon;
      doy_nxt   = f_doy;
      years_nxt = f_years;
      hour_nxt  = f_hour;
      min_nxt   = f_min;
      sec_nxt   = f_sec;
      zone_nxt  = f_zone;
      dst_nxt   = f_dst;
      err_nxt   = f_err;
    end
    if (clr) begin
      phase_nxt  = PH_WDAY;
      acc_nxt    = 16'd0;
      dcnt_nxt   = 2'd0;
      mon_nxt    = 16'd0;
      doy_nxt    = 16'd0;
      years_nxt  = 17'sd0;
      hour_nxt   = 8'd0;
      min_nxt    = 7'd0;
      sec_nxt    = 7'd0;
      zone_nxt   = 4'd0;
      dst_nxt    = 1'b0;
      recent_nxt = 24'd0;
      err_nxt    = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WDAY;
      acc_r       <= 16'd0;
      dcnt_r      <= 2'd0;
      mon_r       <= 16'd0;
      doy_r       <= 16'd0;
      years_r     <= 17'sd0;
      hour_r      <= 8'd0;
      min_r       <= 7'd0;
      sec_r       <= 7'd0;
      zone_r      <= 4'd0;
      dst_r       <= 1'b0;
      recent_r    <= 24'd0;
      err_r       <= ST_OK;
      bstate_r    <= B_RUN;
      flush_cnt_r <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      dcnt_r      <= dcnt_nxt;
      mon_r       <= mon_nxt;
      doy_r       <= doy_nxt;
      years_r     <= years_nxt;
      hour_r      <= hour_nxt;
      min_r       <= min_nxt;
      sec_r       <= sec_nxt;
      zone_r      <= zone_nxt;
      dst_r       <= dst_nxt;
      recent_r    <= recent_nxt;
      err_r       <= err_nxt;
      bstate_r    <= bstate_nxt;
      flush_cnt_r <= flush_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r          <= t_nxt;
    stat_r       <= stat_nxt;
    out_epoch_r  <= out_epoch_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_epoch_seconds = $signed(out_epoch_r);
  assign out_status        = out_status_r;

  a_pop_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (bstate_r == B_RUN))
    else $error("queue popped outside parse state");

  a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (bstate_r == B_FLUSH) |-> (flush_cnt_r <= FLUSH_MAX))
    else $error("flush count beyond limit");

  a_status_epoch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_status_r == ST_OK) || (out_epoch_r == 32'd0)))
    else $error("nonzero epoch with error status");

  a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((bstate_r == B_OUT) && (!out_valid_r || !out_stall))
      |=> (out_valid_r && (phase_r == PH_WDAY) && (bstate_r == B_RUN)))
    else $error("parser not cleared after result load");

endmodule

// ===== rtl/date_text_to_epoch_parser.sv =====
// ----------------------------------------------------------------------------
// date_text_to_epoch_parser
// Parses a date message character by character into epoch seconds and status.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_char_in[7:0], in_last_char
//   out      output     out_valid/out_stall  out_epoch_seconds[31:0], out_status[2:0]
//
// One character per cycle is parsed while the back is in its parse state.
// After the last character the back takes no input while it runs its parse step, 1 to 5
// trailer check and zero-byte flush steps, 4 multiply steps if ok, and 1 load step.
// The character queue keeps taking input during that time until it is full.
// Reset is synchronous and clears parser, queue and result valid.
// A stalled result holds in the output register and delays the next load.
// ----------------------------------------------------------------------------
module date_text_to_epoch_parser
  import dtep_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_in,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_epoch_seconds,
  output logic [2:0]         out_status
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  char_item_t q_wr_item;
  char_item_t q_rd_item;

  dtep_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_in   (in_char_in),
    .in_last_char (in_last_char),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_wr_item)
  );

  dtep_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_item  (q_wr_item),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_rd_item)
  );

  dtep_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_rd_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_epoch_seconds (out_epoch_seconds),
    .out_status        (out_status)
  );

endmodule

// ===== tb/tb_date_text_to_epoch_parser.sv =====
// ----------------------------------------------------------------------------
// tb_date_text_to_epoch_parser
// Streams date messages into the parser one character per transaction and
// checks every epoch/status result against an in-bench parse of the same
// characters. Traffic is mostly well-formed dates with random content, with
// truncated, corrupted and noise messages mixed in. Both channels idle and
// stall at random, with bursts of full rate on each side.
// ----------------------------------------------------------------------------
module tb_date_text_to_epoch_parser;
  import dtep_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_WAIT    = 11;
  localparam int TAIL_CYCLES = 40;
  localparam int RAND_CHARS  = 1600;

  typedef enum logic [3:0] {
    PH_WDAY, PH_DAY, PH_MON, PH_MSKIP, PH_YEAR, PH_HOUR,
    PH_MIN, PH_SEC, PH_HYPH, PH_ZONE, PH_DST, PH_DONE
  } phase_e;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TRAILER    = 3'd1;
  localparam logic [2:0] ST_INCOMPLETE = 3'd2;
  localparam logic [2:0] ST_MONTH      = 3'd3;
  localparam logic [2:0] ST_HYPHEN     = 3'd4;
  localparam logic [2:0] ST_ZONE       = 3'd5;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         hold;
  } char_txn_t;

  typedef struct {
    logic signed [31:0] epoch;
    logic [2:0]         status;
  } stamp_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_char_in = 8'h00;
  logic               in_last_char = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_epoch_seconds;
  logic [2:0]         out_status;

  date_text_to_epoch_parser u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_in        (in_char_in),
    .in_last_char      (in_last_char),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_epoch_seconds (out_epoch_seconds),
    .out_status        (out_status)
  );

  logic [23:0] month_codes [12] = '{"jan", "feb", "mar", "apr", "may", "jun",
                                    "jul", "aug", "sep", "oct", "nov", "dec"};
  logic [15:0] month_offsets [12] = '{16'hFFFF, 16'd30, 16'd59, 16'd90, 16'd120,
                                      16'd151, 16'd181, 16'd212, 16'd243,
                                      16'd273, 16'd304, 16'd334};
  logic [7:0]  zone_chars [7] = '{"p", "m", "c", "e", "a", "y", "h"};
  logic [3:0]  zone_shift [7] = '{4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd9, 4'd10};

  char_txn_t   char_q[$];
  stamp_t      expected_stamps[$];
  logic [7:0]  msg_bytes[$];

  int          error_count = 0;
  int          cycle_count = 0;
  int          chars_sent = 0;
  int          messages_sent = 0;
  int          results_checked = 0;
  int          status_tally [6] = '{0, 0, 0, 0, 0, 0};

  // parse state of the bench copy
  phase_e      p_phase;
  int unsigned p_acc;
  logic [1:0]  p_ndig;
  logic [15:0] p_mon;
  logic [15:0] p_day;
  int          p_years;
  logic [7:0]  p_hour;
  logic [7:0]  p_min;
  logic [7:0]  p_sec;
  logic [3:0]  p_zone;
  logic        p_dst;
  logic [23:0] p_last3;
  logic [2:0]  p_err;

  function automatic void p_clear();
    p_phase = PH_WDAY;
    p_acc   = 0;
    p_ndig  = 2'd0;
    p_mon   = 16'd0;
    p_day   = 16'd0;
    p_years = 0;
    p_hour  = 8'd0;
    p_min   = 8'd0;
    p_sec   = 8'd0;
    p_zone  = 4'd0;
    p_dst   = 1'b0;
    p_last3 = 24'd0;
    p_err   = ST_OK;
  endfunction

  function automatic void p_abort(input logic [2:0] code);
    p_err   = code;
    p_phase = PH_DONE;
  endfunction

  function automatic void p_feed(input logic [7:0] c);
    bit          dig;
    bit          hit;
    int unsigned d;
    int unsigned v;
    int          day;
    int          i;
    dig = (c >= "0" && c <= "9");
    d   = dig ? int'(c - "0") : 0;
    hit = 1'b0;
    case (p_phase)
      PH_WDAY: begin
        if (c == CH_SPACE) p_phase = PH_DAY;
      end
      PH_MSKIP: begin
        if (c == CH_SPACE) p_phase = PH_YEAR;
      end
      PH_DAY, PH_YEAR: begin
        if (dig) begin
          if (p_ndig != 0) begin
            v = p_acc * 10 + d;
            p_acc = (v > 65535) ? 65535 : v;
          end else begin
            p_acc = d;
          end
          p_ndig = 2'd1;
        end else if (p_ndig != 0) begin
          p_ndig = 2'd0;
          if (p_phase == PH_DAY) begin
            p_day   = p_acc[15:0];
            p_mon   = 16'd0;
            p_phase = PH_MON;
          end else begin
            p_years = int'(p_acc) - 70;
            day = int'($signed(p_day));
            if (day > 59 && ((p_years + 2) & 3) != 0) p_day = p_day - 16'd1;
            p_phase = PH_HOUR;
          end
        end
      end
      PH_MON: begin
        if (p_ndig < 2) begin
          p_mon  = {p_mon[7:0], c};
          p_ndig = p_ndig + 2'd1;
        end else begin
          p_ndig = 2'd0;
          for (i = 0; i < 12; i++) begin
            if (!hit && month_codes[i] == {p_mon, c}) begin
              hit   = 1'b1;
              p_day = p_day + month_offsets[i];
            end
          end
          if (hit) p_phase = PH_MSKIP;
          else p_abort(ST_MONTH);
        end
      end
      PH_HOUR, PH_MIN, PH_SEC: begin
        if (p_ndig == 0) begin
          if (dig) begin
            p_acc  = d;
            p_ndig = 2'd1;
          end
        end else begin
          v = dig ? p_acc * 10 + d : p_acc;
          p_ndig = 2'd0;
          case (p_phase)
            PH_HOUR: p_hour = v[7:0];
            PH_MIN:  p_min  = v[7:0];
            default: p_sec  = v[7:0];
          endcase
          p_phase = p_phase.next();
        end
      end
      PH_HYPH: begin
        if (c == CH_HYPHEN) p_phase = PH_ZONE;
        else p_abort(ST_HYPHEN);
      end
      PH_ZONE: begin
        for (i = 0; i < 7; i++) begin
          if (!hit && zone_chars[i] == c) begin
            hit    = 1'b1;
            p_zone = zone_shift[i];
          end
        end
        if (hit) p_phase = PH_DST;
        else p_abort(ST_ZONE);
      end
      PH_DST: begin
        p_dst   = (c == CH_D);
        p_phase = PH_DONE;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] p_epoch();
    int          q;
    int          day;
    int          hr;
    logic [31:0] t;
    q   = (p_years + 1) / 4;
    day = int'($signed(p_day));
    hr  = int'(p_hour) + int'(p_zone) - int'(p_dst);
    t   = p_years * 365 + q + day;
    t   = t * 24 + hr;
    t   = t * 60 + p_min;
    t   = t * 60 + p_sec;
    return t;
  endfunction

  function automatic void predict_char(input logic [7:0] raw, input logic last);
    logic [7:0] c;
    stamp_t     s;
    int         i;
    c = (raw >= "A" && raw <= "Z") ? raw + 8'd32 : raw;
    p_last3 = {p_last3[15:0], raw};
    p_feed(c);
    if (last) begin
      s.epoch = 32'sd0;
      if (p_last3 != TRAILER) begin
        s.status = ST_TRAILER;
      end else begin
        for (i = 0; i < 4 && p_phase != PH_DONE; i++) p_feed(8'h00);
        if (p_phase != PH_DONE) begin
          s.status = ST_INCOMPLETE;
        end else if (p_err != ST_OK) begin
          s.status = p_err;
        end else begin
          s.status = ST_OK;
          s.epoch  = p_epoch();
        end
      end
      expected_stamps.push_back(s);
      status_tally[s.status]++;
      p_clear();
    end
  endfunction

  function automatic void flag_failure(input string what);
    error_count++;
    if (error_count <= 10) $display("%s", what);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] any_case(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 2) == 0) return c - 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] rand_letter();
    return any_case(8'(int'("a") + $urandom_range(0, 25)));
  endfunction

  task automatic put_digits(input int n);
    repeat (n) msg_bytes.push_back(8'(int'("0") + $urandom_range(0, 9)));
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endtask

  task automatic put_trailer();
    msg_bytes.push_back(TRAILER[23:16]);
    msg_bytes.push_back(TRAILER[15:8]);
    msg_bytes.push_back(TRAILER[7:0]);
  endtask

  task automatic enqueue_message(input bit hold);
    char_txn_t t;
    for (int i = 0; i < msg_bytes.size(); i++) begin
      t.ch   = msg_bytes[i];
      t.last = (i == msg_bytes.size() - 1);
      t.hold = hold && (i == 0);
      char_q.push_back(t);
    end
    msg_bytes.delete();
  endtask

  task automatic put_date();
    int m;
    repeat ($urandom_range(0, 5)) msg_bytes.push_back(rand_letter());
    msg_bytes.push_back(CH_SPACE);
    put_digits(($urandom_range(0, 9) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 2));
    msg_bytes.push_back(($urandom_range(0, 5) == 0) ? CH_HYPHEN : CH_SPACE);
    if ($urandom_range(0, 7) == 0) begin
      repeat (3) msg_bytes.push_back(rand_letter());
    end else begin
      m = $urandom_range(0, 11);
      msg_bytes.push_back(any_case(month_codes[m][23:16]));
      msg_bytes.push_back(any_case(month_codes[m][15:8]));
      msg_bytes.push_back(any_case(month_codes[m][7:0]));
    end
    repeat ($urandom_range(0, 2)) msg_bytes.push_back(rand_letter());
    msg_bytes.push_back(CH_SPACE);
    put_digits(($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 2);
    repeat ($urandom_range(1, 2)) msg_bytes.push_back(CH_SPACE);
    put_digits($urandom_range(1, 2));
    put_text(":");
    put_digits($urandom_range(1, 2));
    put_text(":");
    put_digits(($urandom_range(0, 7) == 0) ? 1 : 2);
    msg_bytes.push_back(($urandom_range(0, 11) == 0) ? rand_letter() : CH_HYPHEN);
    msg_bytes.push_back(($urandom_range(0, 9) == 0) ? rand_letter()
                                                     : any_case(zone_chars[$urandom_range(0, 6)]));
    msg_bytes.push_back(any_case(($urandom_range(0, 1) == 0) ? CH_D : "s"));
    put_trailer();
  endtask

  task automatic queue_message(input bit hold);
    int kind;
    int keep;
    int idx;
    kind = $urandom_range(0, 99);
    if (kind < 87) put_date();
    if (kind >= 60 && kind < 75) begin
      keep = $urandom_range(0, msg_bytes.size() - 4);
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
      put_trailer();
    end else if (kind >= 75 && kind < 87) begin
      idx = msg_bytes.size() - 1 - $urandom_range(0, 2);
      msg_bytes[idx] = 8'($urandom_range(0, 255));
    end else if (kind >= 87) begin
      repeat ($urandom_range(1, 40)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) put_trailer();
    end
    enqueue_message(hold);
  endtask

  // ---------------------------------------------------------------- clocking

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_date_text_to_epoch_parser: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driver

  int send_gap = 0;
  bit burst_in = 1'b0;

  always @(posedge clk) begin : drive_chars
    bit        fire;
    char_txn_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) begin
        predict_char(in_char_in, in_last_char);
        chars_sent++;
        if (in_last_char) messages_sent++;
        if ($urandom_range(0, 39) == 0) burst_in = !burst_in;
        send_gap = burst_in ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (!in_valid || fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (char_q.size() != 0 &&
                     !(char_q[0].hold && expected_stamps.size() != 0)) begin
          nxt = char_q.pop_front();
          in_valid     <= 1'b1;
          in_char_in   <= nxt.ch;
          in_last_char <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  int stall_left = 0;
  bit burst_out = 1'b0;

  always @(posedge clk) begin : watch_results
    stamp_t want;
    bit     bad_epoch;
    bit     bad_status;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_stamps.size() == 0) begin
          flag_failure($sformatf("unexpected result: epoch %0d status %0d",
                                 out_epoch_seconds, out_status));
        end else begin
          want = expected_stamps.pop_front();
          bad_epoch  = (out_epoch_seconds !== want.epoch);
          bad_status = (out_status !== want.status);
          if (bad_epoch || bad_status)
            flag_failure($sformatf(
              "result %0d mismatch: epoch %0d exp %0d, status %0d exp %0d",
              results_checked, out_epoch_seconds, want.epoch, out_status,
              want.status));
        end
        if ($urandom_range(0, 9) == 0) burst_out = !burst_out;
        stall_left = burst_out ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run
    int msg_idx;
    p_clear();

    // directed: epoch year, upper case, daylight, then lone extreme bytes
    put_text("X 1 JAN 70 0 0 00-PD");
    put_trailer();
    enqueue_message(1'b0);
    msg_bytes.push_back(8'hFF);
    enqueue_message(1'b0);
    msg_bytes.push_back(8'h00);
    enqueue_message(1'b1);

    msg_idx = 0;
    while (char_q.size() < RAND_CHARS) begin
      queue_message(msg_idx == 5 || $urandom_range(0, 19) == 0);
      msg_idx++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (char_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_stamps.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_stamps.size() != 0)
      flag_failure($sformatf("%0d results never arrived", expected_stamps.size()));

    $display("sent %0d characters in %0d messages, checked %0d results",
             chars_sent, messages_sent, results_checked);
    $display("status mix: ok %0d trailer %0d incomplete %0d month %0d hyphen %0d zone %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4], status_tally[5]);
    if (error_count == 0) begin
      $display("tb_date_text_to_epoch_parser: clean");
    end else begin
      $display("tb_date_text_to_epoch_parser: errors");
    end
    $finish;
  end

endmodule
